// ===== rtl/ipq_pkg.sv =====
// Package for the interrupt pending queue controller.
// Holds sizes, operation and register codes, and the shared struct types.
// No dependencies.
`default_nettype none

package ipq_pkg;

   // Number of interrupt lines and derived widths
   localparam int LINES  = 32;
   localparam int IDX_W  = $clog2(LINES);
   localparam int CNT_W  = $clog2(LINES + 1);
   localparam int LINE_W = 5;
   localparam int FUNC_W = 2;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // Operation codes carried in func
   localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESUME  = 2'd2;

   // Register index of the line enable mask
   localparam logic REG_LINE_ENABLE = 1'b0;

   // Broadcast control for the row of queue cells
   typedef struct packed {
      logic              shift;
      logic              load;
      logic [IDX_W-1:0]  pos;
      logic [LINE_W-1:0] data;
   } cell_ctl_type;

   // One result transaction
   typedef struct packed {
      logic              dispatched;
      logic [LINE_W-1:0] dispatch_line;
      logic              prior_enable;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/ipq_if.sv =====
// Channel interfaces for the interrupt pending queue controller.
// Depends on ipq_pkg for field widths.
`default_nettype none

interface ipq_req_if;
   logic                        valid;
   logic                        ready;
   logic [ipq_pkg::FUNC_W-1:0]  func;
   logic [ipq_pkg::LINE_W-1:0]  line;
   logic                        allowed;

   modport source (output valid, func, line, allowed, input ready);
   modport sink   (input valid, func, line, allowed, output ready);
endinterface

interface ipq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        dispatched;
   logic [ipq_pkg::LINE_W-1:0]  dispatch_line;
   logic                        prior_enable;
   logic                        last;

   modport source (output valid, dispatched, dispatch_line, prior_enable, last, input ready);
   modport sink   (input valid, dispatched, dispatch_line, prior_enable, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/interrupt_pending_queue_controller_unit.sv =====
// Interrupt pending queue controller: top level with control sequencer and APB registers.
// Depends on ipq_pkg, ipq_if (ipq_req_if, ipq_rsp_if) and ipq_queue.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        func, line, allowed
//   rsp_chan  out        valid/ready        dispatched, dispatch_line, prior_enable, last
//   apb       in/out     psel/penable/pready line_enable_mask at byte address 0
//
// A trigger, suspend or non-draining resume yields one transaction.
// A trigger that drops a queued line, and a draining resume, then walk the queue once:
// one step per queued entry, by the one-step shift through the cell row; a dispatching
// step of a draining resume stalls while the output register is full.
// Reset is synchronous: global enable set, queue empty, enable mask cleared.
// A result waits in the output register; take a request once it is empty or drains.
`default_nettype none

module interrupt_pending_queue_controller_unit (
   input  logic                       clock,
   input  logic                       reset,
   ipq_req_if.sink                    req_chan,
   ipq_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ipq_pkg::ADDR_W-1:0] paddr,
   input  logic [ipq_pkg::DATA_W-1:0] pwdata,
   output logic [ipq_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import ipq_pkg::*;

   typedef enum logic {S_IDLE, S_PASS} state_type;

   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_LINES = CNT_W'(LINES);

   // Control state
   state_type         state_ff, state_in;
   logic              ge_ff, ge_in;
   logic [LINES-1:0]  pmask_ff, pmask_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LINES-1:0]  enable_ff, enable_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Pass bookkeeping and result payload
   logic              drain_ff, drain_in;
   logic [LINES-1:0]  drain_set_ff, drain_set_in;
   logic [LINE_W-1:0] target_ff, target_in;
   logic              prior_ff, prior_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   cell_ctl_type      ctl;
   logic [LINE_W-1:0] head;
   logic              accept;
   logic              out_free;
   logic              pass_remove;
   logic              step_go;
   logic              append_go;
   logic              cfg_write;
   logic [CNT_W-1:0]  pass_pos;
   logic [LINES-1:0]  head_bit;

   ipq_queue u_queue (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   // APB register access; pready is always high
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_LINE_ENABLE);
   assign prdata    = (paddr[ADDR_W-1] == REG_LINE_ENABLE) ? DATA_W'(enable_ff) : '0;
   assign enable_in = cfg_write ? pwdata[LINES-1:0] : enable_ff;

   // Handshakes
   assign out_free          = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready    = (state_ff == S_IDLE) && out_free;
   assign accept            = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.dispatched    = rsp_data_ff.dispatched;
   assign rsp_chan.dispatch_line = rsp_data_ff.dispatch_line;
   assign rsp_chan.prior_enable  = rsp_data_ff.prior_enable;
   assign rsp_chan.last          = rsp_data_ff.last;

   // Queue walk: pop the head each step; a kept entry is written back so that,
   // after the remaining shifts of the pass, it lands right behind the earlier kept ones.
   assign head_bit    = LINES'(1) << head;
   assign pass_remove = drain_ff ? drain_set_ff[head] : (head == target_ff);
   assign step_go     = (state_ff == S_PASS) && (!(drain_ff && pass_remove) || out_free);
   assign pass_pos    = kept_ff + total_ff - CNT_ONE - step_ff;

   always_comb begin
      state_in     = state_ff;
      ge_in        = ge_ff;
      pmask_in     = pmask_ff;
      count_in     = count_ff;
      drain_in     = drain_ff;
      drain_set_in = drain_set_ff;
      target_in    = target_ff;
      prior_in     = prior_ff;
      total_in     = total_ff;
      step_in      = step_ff;
      kept_in      = kept_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      append_go    = 1'b0;

      if (accept) begin
         prior_in = ge_ff;
         // Default: acknowledge only
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{dispatched: 1'b0, dispatch_line: '0, prior_enable: ge_ff, last: 1'b1};
         unique case (req_chan.func)
            FUNC_TRIGGER: begin
               if (CNT_W'(req_chan.line) < CNT_LINES) begin
                  if (enable_ff[req_chan.line] && ge_ff) begin
                     rsp_data_in.dispatched    = 1'b1;
                     rsp_data_in.dispatch_line = req_chan.line;
                     if (pmask_ff[req_chan.line]) begin
                        // Drop the line from the queue with one walk
                        pmask_in[req_chan.line] = 1'b0;
                        state_in  = S_PASS;
                        drain_in  = 1'b0;
                        target_in = req_chan.line;
                        total_in  = count_ff;
                        step_in   = '0;
                        kept_in   = '0;
                     end
                  end else if (!pmask_ff[req_chan.line] && (count_ff < CNT_LINES)) begin
                     append_go               = 1'b1;
                     pmask_in[req_chan.line] = 1'b1;
                     count_in                = count_ff + CNT_ONE;
                  end
               end
            end
            FUNC_SUSPEND: begin
               ge_in = 1'b0;
            end
            FUNC_RESUME: begin
               ge_in = req_chan.allowed;
               if (req_chan.allowed && (|(pmask_ff & enable_ff))) begin
                  // Drain: results come from the walk
                  rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                  rsp_data_in  = rsp_data_ff;
                  state_in     = S_PASS;
                  drain_in     = 1'b1;
                  drain_set_in = pmask_ff & enable_ff;
                  total_in     = count_ff;
                  step_in      = '0;
                  kept_in      = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (step_go) begin
         if (pass_remove) begin
            pmask_in = pmask_in & ~head_bit;
            if (drain_ff) begin
               drain_set_in = drain_set_ff & ~head_bit;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{dispatched: 1'b1, dispatch_line: head,
                                prior_enable: prior_ff,
                                last: ((drain_set_ff & ~head_bit) == '0)};
            end
         end else begin
            kept_in = kept_ff + CNT_ONE;
         end
         step_in = step_ff + CNT_ONE;
         if (step_ff == total_ff - CNT_ONE) begin
            count_in = pass_remove ? kept_ff : kept_ff + CNT_ONE;
            state_in = S_IDLE;
         end
      end
   end

   // Cell row control: walk step or append at the tail
   always_comb begin
      ctl.shift = step_go;
      ctl.load  = (step_go && !pass_remove) || append_go;
      ctl.pos   = step_go ? pass_pos[IDX_W-1:0] : count_ff[IDX_W-1:0];
      ctl.data  = step_go ? head : req_chan.line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ge_ff        <= 1'b1;
         pmask_ff     <= '0;
         count_ff     <= '0;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ge_ff        <= ge_in;
         pmask_ff     <= pmask_in;
         count_ff     <= count_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drain_ff     <= drain_in;
      drain_set_ff <= drain_set_in;
      target_ff    <= target_in;
      prior_ff     <= prior_in;
      total_ff     <= total_in;
      step_ff      <= step_in;
      kept_ff      <= kept_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/ipq_cell.sv =====
// One cell of the pending queue: holds one queued line number.
// Loads a broadcast value at its own position, else takes its right neighbor on shift.
// Depends on ipq_pkg.
`default_nettype none

module ipq_cell (
   input  logic                       clock,
   input  ipq_pkg::cell_ctl_type      ctl,
   input  logic [ipq_pkg::IDX_W-1:0]  cell_index,
   input  logic [ipq_pkg::LINE_W-1:0] neighbor,
   output logic [ipq_pkg::LINE_W-1:0] entry
);
   import ipq_pkg::*;

   logic [LINE_W-1:0] entry_ff;
   logic [LINE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load && (ctl.pos == cell_index)) begin
         entry_in = ctl.data;
      end else if (ctl.shift) begin
         entry_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/ipq_queue.sv =====
// Row of queue cells that hold the pending lines in arrival order.
// Cell 0 is the head; each shift moves every entry one cell toward the head.
// Depends on ipq_pkg and ipq_cell.
`default_nettype none

module ipq_queue (
   input  logic                       clock,
   input  ipq_pkg::cell_ctl_type      ctl,
   output logic [ipq_pkg::LINE_W-1:0] head
);
   import ipq_pkg::*;

   logic [LINE_W-1:0] entries [LINES];

   for (genvar i = 0; i < LINES; i++) begin : g_cell
      logic [LINE_W-1:0] right;
      if (i == LINES - 1) begin : g_tail
         assign right = '0;
      end else begin : g_body
         assign right = entries[i+1];
      end

      ipq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(i)),
         .neighbor   (right),
         .entry      (entries[i])
      );
   end

   assign head = entries[0];

endmodule

`default_nettype wire

// ===== rtl/ipq_checker.sv =====
// Port-level checker for the interrupt pending queue controller, bound to the top level.
// Depends on ipq_pkg and ipq_if.
`default_nettype none

module ipq_checker (
   input  logic       clock,
   input  logic       reset,
   ipq_req_if.sink    req_chan,
   ipq_rsp_if.source  rsp_chan
);
   import ipq_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("result dropped while stalled");

   // Acknowledge carries line zero and closes its transaction group
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.dispatched |-> (rsp_chan.dispatch_line == '0) && rsp_chan.last)
      else $error("malformed acknowledge");

   // No new request while a multi-result group is open
   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last |-> !req_chan.ready)
      else $error("request taken inside an open result group");

   // Suspend answers in the next cycle with a single acknowledge
   a_suspend_ack: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.func == FUNC_SUSPEND)
      |=> rsp_chan.valid && rsp_chan.last && !rsp_chan.dispatched)
      else $error("suspend not acknowledged");

endmodule

bind interrupt_pending_queue_controller_unit ipq_checker u_ipq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
